/* hw/rtl/sha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int NUM_WORDS  = 8;
    localparam int NUM_CELLS  = 16;
    localparam int NUM_ROUNDS = 64;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd7;

    localparam logic [31:0] IV_WORDS [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_BYTE,
        CELL_WORD
    } cell_mode_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_cell
// One 32-bit cell of the block buffer chain: shifts in a byte from its
// neighbor while a block fills, or takes the neighbor's whole word per round.
// ----------------------------------------------------------------------------
module sha_cell (
    input  wire logic                clk,
    input  wire sha_pkg::cell_mode_t mode,
    input  wire logic [7:0]          byte_in,
    input  wire logic [31:0]         word_in,
    output logic [31:0]              word_out
);
    import sha_pkg::*;

    logic [31:0] word_reg;
    logic [31:0] word_next;

    always_comb
    begin
        case (mode)
            CELL_BYTE: word_next = {word_reg[23:0], byte_in};
            CELL_WORD: word_next = word_in;
            default:   word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule
`default_nettype wire

/* hw/rtl/sha_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_round
// Working variables a to h and SHA-256 rounds, one a cycle while step is set.
// ----------------------------------------------------------------------------
module sha_round (
    input  wire logic         clk,
    input  wire logic         load,
    input  wire logic         step,
    input  wire logic [31:0]  chain_in [sha_pkg::NUM_WORDS],
    input  wire logic [31:0]  sched_word,
    input  wire logic [31:0]  round_const,
    output logic [31:0]       wv_out [sha_pkg::NUM_WORDS]
);
    import sha_pkg::*;

    logic [31:0] wv_reg  [NUM_WORDS];
    logic [31:0] wv_next [NUM_WORDS];
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        t1 = wv_reg[7] + big_sigma1(wv_reg[4]) + choose(wv_reg[4], wv_reg[5], wv_reg[6])
             + round_const + sched_word;
        t2 = big_sigma0(wv_reg[0]) + majority(wv_reg[0], wv_reg[1], wv_reg[2]);
        wv_next = wv_reg;
        if (load)
        begin
            wv_next = chain_in;
        end
        else if (step)
        begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg <= wv_next;
    end

    assign wv_out = wv_reg;

endmodule
`default_nettype wire

/* hw/rtl/sha256_stream_hasher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream with built-in padding and digest readout.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while in_stall is low into a chain of
// sixteen 32-bit cells that forms the block buffer. When the 64th byte of a
// block arrives, input stalls while the single round unit runs the 64 rounds,
// during which the cell chain shifts one word per cycle and produces the
// message schedule, and while the fold state then adds the result into the
// chaining words. A word with last_byte set is followed by padding
// generated internally at one byte per cycle (9 to 72 bytes, one or two more
// compressions), after which the eight digest words are offered in order,
// one per cycle while out_stall is low. No new input word is taken until the
// last digest word has been taken.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   msg_byte,
    input  wire logic         byte_present,
    input  wire logic         last_byte,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);
    import sha_pkg::*;

    state_t      state_reg;
    state_t      state_next;

    logic [31:0] chain_reg [NUM_WORDS];
    logic [31:0] chain_next [NUM_WORDS];
    logic [60:0] byte_total_reg;
    logic [60:0] byte_total_next;
    logic [5:0]  block_fill_reg;
    logic [5:0]  block_fill_next;
    logic [5:0]  round_step_reg;
    logic [5:0]  round_step_next;
    logic [2:0]  word_idx_reg;
    logic [2:0]  word_idx_next;
    logic        finishing_reg;
    logic        finishing_next;
    logic        pad80_reg;
    logic        pad80_next;
    logic        len_phase_reg;
    logic        len_phase_next;
    logic        pad_done_reg;
    logic        pad_done_next;

    logic        in_acc;
    logic        out_acc;
    logic        emit_end;
    logic        push_en;
    logic        wrap;
    logic [7:0]  push_val;
    logic [7:0]  pad_val;
    logic [7:0]  len_byte;
    logic [63:0] bit_len;
    cell_mode_t  cell_mode;
    logic        wv_load;
    logic        wv_step;

    logic [31:0] cell_word [NUM_CELLS];
    logic [31:0] sched_new;
    logic [31:0] wv [NUM_WORDS];

    // Block buffer: cell 0 holds the oldest schedule word.
    assign sched_new = small_sigma1(cell_word[14]) + cell_word[9]
                       + small_sigma0(cell_word[1]) + cell_word[0];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        if (i == NUM_CELLS - 1)
        begin : g_tail
            sha_cell u_cell (
                .clk      (clk),
                .mode     (cell_mode),
                .byte_in  (push_val),
                .word_in  (sched_new),
                .word_out (cell_word[i])
            );
        end
        else
        begin : g_body
            sha_cell u_cell (
                .clk      (clk),
                .mode     (cell_mode),
                .byte_in  (cell_word[i + 1][31:24]),
                .word_in  (cell_word[i + 1]),
                .word_out (cell_word[i])
            );
        end
    end

    sha_round u_round (
        .clk         (clk),
        .load        (wv_load),
        .step        (wv_step),
        .chain_in    (chain_reg),
        .sched_word  (cell_word[0]),
        .round_const (K_TABLE[round_step_reg]),
        .wv_out      (wv)
    );

    // Handshake and datapath control.
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        in_acc    = in_valid && (state_reg == ST_IDLE);
        out_acc   = out_valid && !out_stall;
        emit_end  = out_acc && (word_idx_reg == WORD_LAST);

        bit_len  = {byte_total_reg, 3'b000};
        len_byte = 8'(bit_len >> {~block_fill_reg[2:0], 3'b000});
        if (!pad80_reg)
        begin
            pad_val = PAD_BYTE;
        end
        else if (len_phase_reg || (block_fill_reg == LEN_START))
        begin
            pad_val = len_byte;
        end
        else
        begin
            pad_val = ZERO_BYTE;
        end

        push_en  = (in_acc && byte_present) || (state_reg == ST_PAD);
        push_val = (state_reg == ST_PAD) ? pad_val : msg_byte;
        wrap     = push_en && (block_fill_reg == FILL_LAST);

        if (push_en)
        begin
            cell_mode = CELL_BYTE;
        end
        else if (state_reg == ST_ROUND)
        begin
            cell_mode = CELL_WORD;
        end
        else
        begin
            cell_mode = CELL_HOLD;
        end

        wv_load = wrap;
        wv_step = (state_reg == ST_ROUND);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (wrap)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (wrap)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_step_reg == ROUND_LAST)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (pad_done_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (emit_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chain_next      = chain_reg;
        byte_total_next = byte_total_reg;
        block_fill_next = block_fill_reg;
        round_step_next = round_step_reg;
        word_idx_next   = word_idx_reg;
        finishing_next  = finishing_reg;
        pad80_next      = pad80_reg;
        len_phase_next  = len_phase_reg;
        pad_done_next   = pad_done_reg;

        if (push_en)
        begin
            block_fill_next = block_fill_reg + 6'd1;
        end
        if (in_acc)
        begin
            finishing_next = last_byte;
            if (byte_present)
            begin
                byte_total_next = byte_total_reg + 61'd1;
            end
        end
        if (state_reg == ST_PAD)
        begin
            pad80_next = 1'b1;
            if (pad80_reg && (block_fill_reg == LEN_START))
            begin
                len_phase_next = 1'b1;
            end
            if (len_phase_reg && (block_fill_reg == FILL_LAST))
            begin
                pad_done_next = 1'b1;
            end
        end
        if (state_reg == ST_ROUND)
        begin
            round_step_next = round_step_reg + 6'd1;
        end
        if (state_reg == ST_FOLD)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + wv[i];
            end
        end
        if (out_acc)
        begin
            word_idx_next = word_idx_reg + 3'd1;
        end
        if (emit_end)
        begin
            chain_next      = IV_WORDS;
            byte_total_next = '0;
            finishing_next  = 1'b0;
            pad80_next      = 1'b0;
            len_phase_next  = 1'b0;
            pad_done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chain_reg      <= IV_WORDS;
            byte_total_reg <= '0;
            block_fill_reg <= '0;
            round_step_reg <= '0;
            word_idx_reg   <= '0;
            finishing_reg  <= 1'b0;
            pad80_reg      <= 1'b0;
            len_phase_reg  <= 1'b0;
            pad_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            byte_total_reg <= byte_total_next;
            block_fill_reg <= block_fill_next;
            round_step_reg <= round_step_next;
            word_idx_reg   <= word_idx_next;
            finishing_reg  <= finishing_next;
            pad80_reg      <= pad80_next;
            len_phase_reg  <= len_phase_next;
            pad_done_reg   <= pad_done_next;
        end
    end

    assign digest_word = chain_reg[word_idx_reg];
    assign word_index  = word_idx_reg;
    assign last_word   = (word_idx_reg == WORD_LAST);

endmodule
`default_nettype wire

/* hw/rtl/sha_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 stream hasher's digest readout.
// ----------------------------------------------------------------------------
module sha_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_stall,
    input  wire logic         out_valid,
    input  wire logic         out_stall,
    input  wire logic [31:0]  digest_word,
    input  wire logic [2:0]   word_index,
    input  wire logic         last_word
);

    // The digest words come out in order without gaps.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_word) |=>
        (out_valid && (word_index == 3'($past(word_index) + 3'd1))))
        else $error("digest word index did not advance by one");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match the final word position");

    // No new message word is taken while the digest is being read out.
    a_input_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted during digest readout");

    a_readout_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_word) |=> !out_valid)
        else $error("output still valid after the final digest word");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(digest_word) && $stable(word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
`default_nettype wire

/* test/sha256_stream_hasher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking testbench for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own SHA-256 state and computes the eight digest
// words of every finished message. Each digest word that the block hands out
// is compared against the oldest predicted word. Directed messages cover the
// empty message, single bytes at both extremes, words with no byte and
// messages ended by a word that carries no byte. Random messages follow, with
// lengths up to 20 or around the padding and block boundaries, under several
// idling patterns and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;
    localparam int NOISE_PCT    = 8;

    localparam bit [7:0] PAD_MARK      = 8'h80;
    localparam bit [5:0] LENGTH_OFFSET = 6'd56;
    localparam int BOUNDARY_LENGTHS [8] = '{1, 55, 56, 57, 63, 64, 65, 119};

    localparam bit [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_CONSTS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        bit [31:0] value;
        bit [2:0]  index;
        bit        last;
    } digest_entry_t;

    class digest_scoreboard;
        bit [31:0]     chain [8];
        bit [31:0]     block_words [16];
        bit [60:0]     byte_count;
        bit [5:0]      fill;
        digest_entry_t expected_words [$];
        int unsigned   errors;

        function new();
            chain = START_HASH;
            byte_count = '0;
            fill = '0;
            errors = 0;
        endfunction

        function bit [31:0] ror(input bit [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] v [8];
            bit [31:0] sched [64];
            bit [31:0] t1;
            bit [31:0] t2;
            bit [31:0] s0;
            bit [31:0] s1;
            int t;
            for (t = 0; t < 16; t++)
                sched[t] = block_words[t];
            for (t = 16; t < 64; t++)
            begin
                s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
            end
            v = chain;
            for (t = 0; t < 64; t++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONSTS[t] + sched[t];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (t = 0; t < 8; t++)
                chain[t] += v[t];
        endfunction

        function void add_byte(input bit [7:0] b);
            bit [31:0] shifted;
            shifted = {24'b0, b} << (24 - 8 * fill[1:0]);
            if (fill[1:0] == 2'd0)
                block_words[fill[5:2]] = shifted;
            else
                block_words[fill[5:2]] |= shifted;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress();
        endfunction

        function void note_input(input bit [7:0] b, input bit present, input bit last);
            bit [63:0] bit_length;
            digest_entry_t entry;
            int i;
            if (present)
            begin
                add_byte(b);
                byte_count = byte_count + 61'd1;
            end
            if (!last)
                return;
            bit_length = {byte_count, 3'b000};
            add_byte(PAD_MARK);
            while (fill != LENGTH_OFFSET)
                add_byte(8'h00);
            for (i = 0; i < 8; i++)
                add_byte(bit_length[63 - 8 * i -: 8]);
            for (i = 0; i < 8; i++)
            begin
                entry.value = chain[i];
                entry.index = 3'(i);
                entry.last = (i == 7);
                expected_words.push_back(entry);
            end
            chain = START_HASH;
            byte_count = '0;
            fill = '0;
        endfunction

        function void check_result(input logic [31:0] value, input logic [2:0] index,
                                   input logic last);
            digest_entry_t entry;
            if (expected_words.size() == 0)
            begin
                $error("digest_word: no word expected, actual %h", value);
                errors++;
                return;
            end
            entry = expected_words.pop_front();
            if (value !== entry.value)
            begin
                $error("digest_word: expected %h, actual %h", entry.value, value);
                errors++;
            end
            if (index !== entry.index)
            begin
                $error("word_index: expected %0d, actual %0d", entry.index, index);
                errors++;
            end
            if (last !== entry.last)
            begin
                $error("last_word: expected %0d, actual %0d", entry.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  msg_byte;
    logic        byte_present;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    digest_scoreboard sb = new();
    idle_mode_t       idle_mode = IDLE_NONE;
    int unsigned      items_sent = 0;

    sha256_stream_hasher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .msg_byte     (msg_byte),
        .byte_present (byte_present),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int sender_gap_pct();
        case (idle_mode)
            IDLE_SENDER: return 77;
            IDLE_BOTH:   return 12;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 77;
            IDLE_BOTH:     return 12;
            default:       return 0;
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(99) < 15)
            return BOUNDARY_LENGTHS[$urandom_range(7)];
        return $urandom_range(20);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(99) < sender_gap_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        msg_byte     <= b;
        byte_present <= present;
        last_byte    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(b, present, last);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        bit end_on_byte;
        int i;
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < NOISE_PCT)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial
    begin : digest_sink
        int hold_left;
        int taken;
        bit held;
        hold_left = 0;
        taken = 0;
        held = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                sb.check_result(digest_word, word_index, last_word);
                taken++;
            end
            if (!held && taken >= 16)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL sha256_stream_hasher");
        $finish;
    end

    initial
    begin : stimulus
        int msg_count;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        msg_byte     = 8'h00;
        byte_present = 1'b0;
        last_byte    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);

        msg_count = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_mode = idle_mode_t'((msg_count / 2) % 4);
            send_message(pick_length());
            msg_count++;
        end
        in_valid <= 1'b0;
        idle_mode = IDLE_NONE;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS sha256_stream_hasher");
        else
            $display("FAIL sha256_stream_hasher");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sha_pkg.sv
hw/rtl/sha_cell.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_stream_hasher.sv
hw/rtl/sha_checker.sv
test/sha256_stream_hasher_tb.sv
